>>> design/bxg_pkg.sv
`timescale 1ns / 1ps

package bxg_pkg;

	localparam int WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STRIP,
		ST_LOOP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic strip;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic zero_in;
		logic odd;
		logic last;
	} sts_t;

endpackage

>>> design/bxg_ctrl.sv
`timescale 1ns / 1ps

module bxg_ctrl
	import bxg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.zero_in ? ST_EMIT : ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (sts.odd) begin
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sts.last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_STRIP: begin
				cmd.strip = 1'b1;
			end
			ST_LOOP: begin
				cmd.step = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/bxg_datapath.sv
`timescale 1ns / 1ps

module bxg_datapath
	import bxg_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] operand_x,
	input  logic [WIDTH-1:0] operand_y,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic [WIDTH-1:0] gcd_value,
	output logic [WIDTH:0]   coef_a,
	output logic [WIDTH:0]   coef_b,
	output logic             invalid
);

	localparam int CW = (WIDTH + 3 > 64) ? 64 : WIDTH + 3;
	localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] x_q, y_q, u_q, v_q;
	logic [KW-1:0]    k_q;
	logic             zero_q;
	logic [CW-1:0]    ca_q, cb_q, cc_q, cd_q;

	logic [WIDTH-1:0] gcd_q;
	logic [WIDTH:0]   coef_a_q, coef_b_q;
	logic             invalid_q;

	logic [CW:0]   y_ext, xn_ext;
	logic [CW:0]   sum_a, sum_b, sum_c, sum_d;
	logic [CW-1:0] half_a, half_b, half_c, half_d;
	logic          odd_ab, odd_cd;
	logic          u_ge;

	assign y_ext  = {{(CW + 1 - WIDTH){1'b0}}, y_q};
	assign xn_ext = (CW + 1)'(0) - {{(CW + 1 - WIDTH){1'b0}}, x_q};

	assign odd_ab = ca_q[0] | cb_q[0];
	assign odd_cd = cc_q[0] | cd_q[0];

	assign sum_a = {ca_q[CW-1], ca_q} + y_ext;
	assign sum_b = {cb_q[CW-1], cb_q} + xn_ext;
	assign sum_c = {cc_q[CW-1], cc_q} + y_ext;
	assign sum_d = {cd_q[CW-1], cd_q} + xn_ext;

	assign half_a = odd_ab ? sum_a[CW:1] : {ca_q[CW-1], ca_q[CW-1:1]};
	assign half_b = odd_ab ? sum_b[CW:1] : {cb_q[CW-1], cb_q[CW-1:1]};
	assign half_c = odd_cd ? sum_c[CW:1] : {cc_q[CW-1], cc_q[CW-1:1]};
	assign half_d = odd_cd ? sum_d[CW:1] : {cd_q[CW-1], cd_q[CW-1:1]};

	assign u_ge = (u_q >= v_q);

	assign sts.zero_in = (operand_x == '0) || (operand_y == '0);
	assign sts.odd     = x_q[0] | y_q[0];
	assign sts.last    = u_q[0] & v_q[0] & (u_q == v_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= operand_x;
			y_q    <= operand_y;
			k_q    <= '0;
			zero_q <= sts.zero_in;
		end
		if (cmd.strip) begin
			if (!sts.odd) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + KW'(1);
			end else begin
				u_q  <= x_q;
				v_q  <= y_q;
				ca_q <= CW'(1);
				cb_q <= '0;
				cc_q <= '0;
				cd_q <= CW'(1);
			end
		end
		if (cmd.step) begin
			if (!u_q[0]) begin
				u_q  <= u_q >> 1;
				ca_q <= half_a;
				cb_q <= half_b;
			end else if (!v_q[0]) begin
				v_q  <= v_q >> 1;
				cc_q <= half_c;
				cd_q <= half_d;
			end else if (u_ge) begin
				u_q  <= u_q - v_q;
				ca_q <= ca_q - cc_q;
				cb_q <= cb_q - cd_q;
			end else begin
				v_q  <= v_q - u_q;
				cc_q <= cc_q - ca_q;
				cd_q <= cd_q - cb_q;
			end
		end
		if (cmd.emit) begin
			invalid_q <= zero_q;
			if (zero_q) begin
				gcd_q    <= '0;
				coef_a_q <= '0;
				coef_b_q <= '0;
			end else begin
				gcd_q    <= v_q << k_q;
				coef_a_q <= cc_q[WIDTH:0];
				coef_b_q <= cd_q[WIDTH:0];
			end
		end
	end

	assign gcd_value = gcd_q;
	assign coef_a    = coef_a_q;
	assign coef_b    = coef_b_q;
	assign invalid   = invalid_q;

endmodule

>>> design/binary_extended_gcd.sv
`timescale 1ns / 1ps

// Binary extended GCD.
// Input word (in_valid/in_ready): operand_x, operand_y, both unsigned.
// Output word (out_valid/out_ready): gcd_value, Bezout coefficients coef_a and
// coef_b (two's complement, for the operands with common factors of two
// removed) and invalid, set with all other fields zero when an operand is 0.
// One operand pair is processed at a time. After acceptance the block strips
// the common factors of two, then runs the halvings and subtractions of the
// reduction loop, then loads the output register and returns to idle. A zero
// operand skips the strip and loop and goes straight to the output register.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register; a new pair is accepted while it
// waits. If the receiver stalls, the next result holds in the datapath until
// the output register is taken.
// Reset (arst_n low) returns the sequencer to idle and drops out_valid.
module binary_extended_gcd
	import bxg_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] operand_x,
	input  logic [WIDTH-1:0] operand_y,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] gcd_value,
	output logic [WIDTH:0]   coef_a,
	output logic [WIDTH:0]   coef_b,
	output logic             invalid
);

	cmd_t cmd;
	sts_t sts;

	bxg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bxg_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk       (clk),
		.operand_x (operand_x),
		.operand_y (operand_y),
		.cmd       (cmd),
		.sts       (sts),
		.gcd_value (gcd_value),
		.coef_a    (coef_a),
		.coef_b    (coef_b),
		.invalid   (invalid)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a word was accepted");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> gcd_value == '0 && coef_a == '0 && coef_b == '0)
		else $error("invalid result carries nonzero fields");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> gcd_value != '0)
		else $error("valid result with zero gcd");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.strip, cmd.step, cmd.emit}))
		else $error("more than one datapath command");

endmodule
